FILE: src/gsa_pkg.sv
// Shared constants, codes and types for the generational slot allocator.
package gsa_pkg;

	localparam int POOL_SLOTS = 128;
	localparam int GEN_BITS   = 16;
	localparam int IDX_W      = $clog2(POOL_SLOTS);
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

	// fixed field widths of the ports
	localparam int HIDX_W = 7;
	localparam int HGEN_W = 17;
	localparam int OGEN_W = 16;
	localparam int POS_W  = 32;
	localparam int ST_W   = 3;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [ST_W-1:0] ST_ACQUIRED = 3'd0;
	localparam logic [ST_W-1:0] ST_RELEASED = 3'd1;
	localparam logic [ST_W-1:0] ST_NULL     = 3'd2;
	localparam logic [ST_W-1:0] ST_STALE    = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

	localparam logic [HGEN_W-1:0] HGEN_NULL = {HGEN_W{1'b1}};

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} push_t;

	typedef struct packed {
		logic                en;
		logic                xy_en;
		logic [IDX_W-1:0]    addr;
		logic                busy;
		logic [GEN_BITS-1:0] gen;
	} slot_wr_t;

endpackage

FILE: src/gsa_free_stack.sv
// LIFO free-slot stack in a synchronous memory, with count and low-water mark.
module gsa_free_stack (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pop,
	input  gsa_pkg::push_t             push,
	output logic                       empty,
	output logic [gsa_pkg::IDX_W-1:0]  pop_idx
);

	logic [gsa_pkg::IDX_W-1:0] mem [gsa_pkg::POOL_SLOTS];
	logic [gsa_pkg::CNT_W-1:0] count_q;
	logic [gsa_pkg::CNT_W-1:0] low_q;
	logic [gsa_pkg::CNT_W-1:0] top_pos;
	logic                      full;
	logic [gsa_pkg::IDX_W-1:0] rd_q;
	logic [gsa_pkg::IDX_W-1:0] orig_q;
	logic                      orig_sel_q;

	assign top_pos = count_q - gsa_pkg::CNT_W'(1);
	assign empty   = (count_q == '0);
	assign full    = (count_q == gsa_pkg::CNT_W'(gsa_pkg::POOL_SLOTS));

	// Entries in [low_q, count_q) were pushed since reset; below low_q the
	// stack still holds its reset fill, slot 0 on top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= gsa_pkg::CNT_W'(gsa_pkg::POOL_SLOTS);
			low_q   <= gsa_pkg::CNT_W'(gsa_pkg::POOL_SLOTS);
		end else if (pop) begin
			count_q <= top_pos;
			if (top_pos < low_q) begin
				low_q <= top_pos;
			end
		end else if (push.en && !full) begin
			count_q <= count_q + gsa_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push.en && !full) begin
			mem[count_q[gsa_pkg::IDX_W-1:0]] <= push.idx;
		end
		if (pop) begin
			rd_q       <= mem[top_pos[gsa_pkg::IDX_W-1:0]];
			orig_sel_q <= (top_pos < low_q);
			orig_q     <= gsa_pkg::IDX_W'(gsa_pkg::POOL_SLOTS - 1)
				- top_pos[gsa_pkg::IDX_W-1:0];
		end
	end

	assign pop_idx = orig_sel_q ? orig_q : rd_q;

endmodule

FILE: src/gsa_slot_table.sv
// Per-slot busy bit, generation and position words, in synchronous memories.
module gsa_slot_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [gsa_pkg::IDX_W-1:0]     rd_addr,
	input  gsa_pkg::slot_wr_t             wr,
	input  logic [gsa_pkg::POS_W-1:0]     wr_x,
	input  logic [gsa_pkg::POS_W-1:0]     wr_y,
	output logic                          rd_busy,
	output logic [gsa_pkg::GEN_BITS-1:0]  rd_gen
);

	logic [gsa_pkg::GEN_BITS:0]      mem   [gsa_pkg::POOL_SLOTS];
	logic [gsa_pkg::POS_W-1:0]       x_mem [gsa_pkg::POOL_SLOTS];
	logic [gsa_pkg::POS_W-1:0]       y_mem [gsa_pkg::POOL_SLOTS];
	logic [gsa_pkg::POOL_SLOTS-1:0]  valid_q;
	logic [gsa_pkg::GEN_BITS:0]      rd_q;
	logic                            rd_vld_q;

	// never-written entries read as not busy, generation zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.busy, wr.gen};
		end
		if (wr.xy_en) begin
			x_mem[wr.addr] <= wr_x;
			y_mem[wr.addr] <= wr_y;
		end
		if (rd_en) begin
			rd_q     <= mem[rd_addr];
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	assign rd_busy = rd_vld_q & rd_q[gsa_pkg::GEN_BITS];
	assign rd_gen  = rd_vld_q ? rd_q[gsa_pkg::GEN_BITS-1:0] : '0;

endmodule

FILE: src/generational_slot_allocator_top.sv
// Top level of the generational slot allocator: sequencer and result register.
//
//  channel | direction | handshake           | beat contents
//  --------+-----------+---------------------+----------------------------------------------
//  in      | input     | in_valid / in_ready | op, pos_x, pos_y, handle_index, handle_generation
//  out     | output    | out_valid/out_ready | status, slot_index, slot_generation
//
// One item at a time. Acquire reads the stack, then reads the slot table
// at the popped index, then writes back; release reads the slot table,
// then compares and writes back; null handles and empty-pool acquires skip these steps.
// The slot table read for an acquire depends on the stack read, which sets this order.
// Reset leaves every slot free with generation zero; no clearing pass.
// A held result stalls only the item behind it; the next beat is accepted meanwhile.
module generational_slot_allocator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic [gsa_pkg::POS_W-1:0]           pos_x,
	input  logic [gsa_pkg::POS_W-1:0]           pos_y,
	input  logic [gsa_pkg::HIDX_W-1:0]          handle_index,
	input  logic signed [gsa_pkg::HGEN_W-1:0]   handle_generation,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [gsa_pkg::ST_W-1:0]            status,
	output logic [gsa_pkg::HIDX_W-1:0]          slot_index,
	output logic [gsa_pkg::OGEN_W-1:0]          slot_generation
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POP  = 3'd1;
	localparam logic [2:0] S_ACQ  = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]                       state_q;
	logic [2:0]                       state_d;
	logic                             in_acc;
	logic                             is_null;
	logic                             pop;
	logic                             empty;
	logic [gsa_pkg::IDX_W-1:0]        pop_idx;
	gsa_pkg::push_t                   push;
	gsa_pkg::slot_wr_t                slot_wr;
	logic                             rd_en;
	logic [gsa_pkg::IDX_W-1:0]        rd_addr;
	logic                             rd_busy;
	logic [gsa_pkg::GEN_BITS-1:0]     rd_gen;
	logic                             in_pool;
	logic                             gen_match;
	logic                             rel_ok;
	logic                             fin_load;

	logic [gsa_pkg::POS_W-1:0]        pos_x_q;
	logic [gsa_pkg::POS_W-1:0]        pos_y_q;
	logic [gsa_pkg::HIDX_W-1:0]       hidx_q;
	logic [gsa_pkg::HGEN_W-1:0]       hgen_q;
	logic [gsa_pkg::IDX_W-1:0]        acq_idx_q;
	logic [gsa_pkg::ST_W-1:0]         res_status_q;
	logic [gsa_pkg::HIDX_W-1:0]       res_idx_q;
	logic [gsa_pkg::OGEN_W-1:0]       res_gen_q;
	logic                             out_valid_q;
	logic [gsa_pkg::ST_W-1:0]         status_q;
	logic [gsa_pkg::HIDX_W-1:0]       slot_index_q;
	logic [gsa_pkg::OGEN_W-1:0]       slot_generation_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign is_null  = (handle_generation == gsa_pkg::HGEN_NULL);
	assign pop      = in_acc && (op == gsa_pkg::OP_ACQUIRE) && !empty;
	assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign rd_en   = (in_acc && (op == gsa_pkg::OP_RELEASE) && !is_null)
		|| (state_q == S_POP);
	assign rd_addr = (state_q == S_POP) ? pop_idx : gsa_pkg::IDX_W'(handle_index);

	assign in_pool   = ({1'b0, hidx_q} < (gsa_pkg::HIDX_W + 1)'(gsa_pkg::POOL_SLOTS));
	assign gen_match = !hgen_q[gsa_pkg::HGEN_W-1]
		&& (hgen_q[gsa_pkg::HGEN_W-2:0] == (gsa_pkg::HGEN_W - 1)'(rd_gen));
	assign rel_ok    = (state_q == S_CHK) && in_pool && rd_busy && gen_match;

	always_comb begin
		slot_wr       = '0;
		slot_wr.addr  = acq_idx_q;
		slot_wr.busy  = 1'b1;
		slot_wr.gen   = rd_gen;
		push          = '0;
		push.idx      = gsa_pkg::IDX_W'(hidx_q);
		if (state_q == S_ACQ) begin
			slot_wr.en    = 1'b1;
			slot_wr.xy_en = 1'b1;
		end else if (rel_ok) begin
			slot_wr.en   = 1'b1;
			slot_wr.addr = gsa_pkg::IDX_W'(hidx_q);
			slot_wr.busy = 1'b0;
			slot_wr.gen  = rd_gen + gsa_pkg::GEN_BITS'(1);
			push.en      = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (op == gsa_pkg::OP_ACQUIRE) begin
						state_d = empty ? S_FIN : S_POP;
					end else begin
						state_d = is_null ? S_FIN : S_CHK;
					end
				end
			end
			S_POP: state_d = S_ACQ;
			S_ACQ: state_d = S_FIN;
			S_CHK: state_d = S_FIN;
			S_FIN: begin
				if (fin_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			hidx_q  <= handle_index;
			hgen_q  <= handle_generation;
			res_idx_q <= '0;
			res_gen_q <= '0;
			if (op == gsa_pkg::OP_ACQUIRE) begin
				res_status_q <= gsa_pkg::ST_EMPTY;
			end else begin
				res_status_q <= is_null ? gsa_pkg::ST_NULL : gsa_pkg::ST_STALE;
			end
		end
		if (state_q == S_POP) begin
			acq_idx_q <= pop_idx;
		end
		if (state_q == S_ACQ) begin
			res_status_q <= gsa_pkg::ST_ACQUIRED;
			res_idx_q    <= gsa_pkg::HIDX_W'(acq_idx_q);
			res_gen_q    <= gsa_pkg::OGEN_W'(rd_gen);
		end
		if (rel_ok) begin
			res_status_q <= gsa_pkg::ST_RELEASED;
		end
		if (fin_load) begin
			status_q          <= res_status_q;
			slot_index_q      <= res_idx_q;
			slot_generation_q <= res_gen_q;
		end
	end

	gsa_free_stack u_free_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop     (pop),
		.push    (push),
		.empty   (empty),
		.pop_idx (pop_idx)
	);

	gsa_slot_table u_slot_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr      (slot_wr),
		.wr_x    (pos_x_q),
		.wr_y    (pos_y_q),
		.rd_busy (rd_busy),
		.rd_gen  (rd_gen)
	);

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign slot_index      = slot_index_q;
	assign slot_generation = slot_generation_q;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the generational slot allocator with a built-in pool predictor.
module tb;
	import gsa_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [HIDX_W-1:0] index;
		logic [OGEN_W-1:0] generation;
	} grant_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       op;
	logic [POS_W-1:0]           pos_x;
	logic [POS_W-1:0]           pos_y;
	logic [HIDX_W-1:0]          handle_index;
	logic signed [HGEN_W-1:0]   handle_generation;
	logic                       out_valid;
	logic                       out_ready;
	logic [ST_W-1:0]            status;
	logic [HIDX_W-1:0]          slot_index;
	logic [OGEN_W-1:0]          slot_generation;

	// predicted pool state
	logic [IDX_W-1:0]    free_lifo [POOL_SLOTS];
	int                  free_depth;
	bit                  slot_held [POOL_SLOTS];
	logic [OGEN_W-1:0]   slot_gen_now [POOL_SLOTS];
	grant_t              grant_q [$];

	int idle_pct;
	int stall_pct;
	int n_err;
	int n_beats;
	int status_seen [5];

	generational_slot_allocator_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic void note_error(string msg);
		n_err++;
		if (n_err <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < POOL_SLOTS; i++) begin
			free_lifo[i] = IDX_W'(POOL_SLOTS - 1 - i);
			slot_held[i] = 1'b0;
			slot_gen_now[i] = '0;
		end
		free_depth = POOL_SLOTS;
	endfunction

	// one accepted beat: update the pool and queue the grant it must produce
	function automatic void allocate_predict(logic o, logic [HIDX_W-1:0] hi,
			logic signed [HGEN_W-1:0] hg);
		grant_t g;
		logic [IDX_W-1:0] s;
		g = '0;
		if (o == OP_ACQUIRE) begin
			if (free_depth == 0) begin
				g.status = ST_EMPTY;
			end else begin
				free_depth--;
				s = free_lifo[free_depth];
				slot_held[s] = 1'b1;
				g = '{ST_ACQUIRED, s, slot_gen_now[s]};
			end
		end else if (hg == HGEN_NULL) begin
			g.status = ST_NULL;
		end else if (hg[HGEN_W-1] || !slot_held[hi] ||
				slot_gen_now[hi] != hg[OGEN_W-1:0]) begin
			g.status = ST_STALE;
		end else begin
			slot_held[hi] = 1'b0;
			slot_gen_now[hi] = slot_gen_now[hi] + 1'b1;
			free_lifo[free_depth] = hi;
			free_depth++;
			g.status = ST_RELEASED;
		end
		status_seen[g.status]++;
		grant_q = {grant_q, g};
	endfunction

	task automatic send_item(logic o, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
			logic [HIDX_W-1:0] hi, logic signed [HGEN_W-1:0] hg);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		pos_x <= x;
		pos_y <= y;
		handle_index <= hi;
		handle_generation <= hg;
		do @(posedge clk); while (!in_ready);
		allocate_predict(o, hi, hg);
		n_beats++;
	endtask

	task automatic acquire_slot(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
		send_item(OP_ACQUIRE, x, y, HIDX_W'($urandom), HGEN_W'($urandom));
	endtask

	task automatic release_handle(logic [HIDX_W-1:0] hi, logic signed [HGEN_W-1:0] hg);
		send_item(OP_RELEASE, $urandom, $urandom, hi, hg);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
	endtask

	// result side: random backpressure, compare against oldest grant
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && $isunknown(out_valid))
			note_error("out_valid unknown");
		if (arst_n && out_valid && out_ready) begin
			if (grant_q.size() == 0) begin
				note_error($sformatf("unexpected beat: status %0d index %0d gen %0d",
					status, slot_index, slot_generation));
			end else begin
				want = grant_q.pop_front();
				if ({status, slot_index, slot_generation} !== want)
					note_error($sformatf(
						"expected status %0d index %0d gen %0d, got %0d %0d %0d",
						want.status, want.index, want.generation,
						status, slot_index, slot_generation));
			end
		end
	end

	task automatic test_directed();
		idle_pct = 31;
		stall_pct = 31;
		acquire_slot('0, '0);
		acquire_slot('1, '1);
		acquire_slot(32'hAAAA_AAAA, 32'h5555_5555);
		release_handle(7'd1, 17'sd0);
		release_handle(7'd1, 17'sd0);               // slot already free
		acquire_slot(32'h5555_5555, 32'hAAAA_AAAA); // slot 1 back with gen 1
		release_handle(7'd1, 17'sd0);               // old generation
		release_handle(7'd1, 17'sd1);
		release_handle(7'd127, HGEN_NULL);
		release_handle(7'd0, HGEN_NULL);
		release_handle(7'd0, -17'sd2);              // negative but not null
		release_handle(7'd0, 17'sh10000);           // most negative
		release_handle(7'd0, 17'sd65535);
		release_handle(7'd127, 17'sd0);             // never acquired
		release_handle(7'd0, 17'sd0);
		release_handle(7'd2, 17'sd0);
		acquire_slot(32'h8000_0000, 32'h0000_0001);
		release_handle(7'd2, 17'sd1);
		wait_drained();
	endtask

	task automatic test_exhaustion();
		logic [HIDX_W-1:0] s;
		int off;
		idle_pct = 31;
		stall_pct = 31;
		while (free_depth > 0)
			acquire_slot($urandom, $urandom);
		repeat (3) acquire_slot($urandom, $urandom);
		wait_drained();
		// odd stride walks every slot once
		off = $urandom_range(POOL_SLOTS - 1);
		for (int k = 0; k < POOL_SLOTS; k++) begin
			s = HIDX_W'((k * 37 + off) % POOL_SLOTS);
			release_handle(s, {1'b0, slot_gen_now[s]});
		end
		release_handle(s, {1'b0, slot_gen_now[s] - 1'b1});
		wait_drained();
	endtask

	// no idling on either side here: back-to-back beats on one slot
	task automatic test_slot_reuse();
		logic [IDX_W-1:0] s;
		idle_pct = 0;
		stall_pct = 0;
		s = free_lifo[free_depth - 1];
		repeat (32) begin
			acquire_slot($urandom, $urandom);
			release_handle(s, {1'b0, slot_gen_now[s]});
		end
		acquire_slot($urandom, $urandom);
		release_handle(s, {1'b0, {OGEN_W{1'b1}}});
		release_handle(s, {1'b0, slot_gen_now[s]});
		wait_drained();
	endtask

	task automatic test_random(int n_items);
		int acq_pct;
		int pick;
		int left_in_phase;
		logic [HIDX_W-1:0] s;
		idle_pct = 31;
		stall_pct = 31;
		acq_pct = 75;
		left_in_phase = $urandom_range(150, 300);
		for (int k = 0; k < n_items; k++) begin
			// swing between filling and emptying the pool
			if (left_in_phase == 0) begin
				acq_pct = 100 - acq_pct;
				left_in_phase = $urandom_range(150, 300);
			end
			left_in_phase--;
			if ($urandom_range(199) == 0)
				wait_drained();
			s = HIDX_W'($urandom_range(POOL_SLOTS - 1));
			pick = $urandom_range(99);
			if (pick < acq_pct) begin
				acquire_slot($urandom, $urandom);
			end else begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					repeat (POOL_SLOTS)
						if (!slot_held[s]) s++;
					release_handle(s, {1'b0, slot_gen_now[s]});
				end else if (pick < 80) begin
					release_handle(s, HGEN_NULL);
				end else if (pick < 90) begin
					release_handle(s, {1'b0, slot_gen_now[s] - 1'b1});
				end else begin
					release_handle(s, HGEN_W'($urandom));
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ACQUIRE;
		pos_x = '0;
		pos_y = '0;
		handle_index = '0;
		handle_generation = '0;
		out_ready = 1'b0;
		idle_pct = 31;
		stall_pct = 31;
		n_err = 0;
		n_beats = 0;
		pool_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_exhaustion();
		test_slot_reuse();
		test_random(1200);

		repeat (20) @(posedge clk);
		$display("%0d beats: %0d acquired, %0d released, %0d null, %0d stale, %0d empty; %0d errors",
			n_beats, status_seen[ST_ACQUIRED], status_seen[ST_RELEASED],
			status_seen[ST_NULL], status_seen[ST_STALE], status_seen[ST_EMPTY], n_err);
		$display("covered corner handles, full pool drain and refill, back-to-back slot reuse");
		if (n_err == 0 && grant_q.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
